FILE: rtl/core/cism_pkg.sv
// cism_pkg: shared constants, codes and helpers for the case-insensitive
// substring matcher. No dependencies; imported by every module of the block.
package cism_pkg;

   // default depth of the character window
   localparam int PATTERN_MAX_DEFAULT = 32;
   // characters held by the four pattern registers
   localparam int PATTERN_REG_CHARS   = 32;
   localparam int PATTERN_BITS        = PATTERN_REG_CHARS * 8;

   // field widths
   localparam int CMD_W   = 2;
   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 6;
   localparam int COUNT_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // per-line character count saturates here
   localparam logic [LEN_W-1:0] CHARS_CAP = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // input commands
   typedef enum logic [CMD_W-1:0] {
      CMD_CHAR = 2'd0,
      CMD_EOL  = 2'd1,
      CMD_EOT  = 2'd2
   } cmd_type;

   // result kinds
   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_SEC  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_THD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH = 3'd4;

   // fold ascii upper case to lower case, other bytes pass unchanged
   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/cism_window_compare.sv
// cism_window_compare: parallel compare of the character window against the
// right-aligned pattern of the active length. Depends on cism_pkg.
module cism_window_compare
   import cism_pkg::*;
#(
   parameter int WIN_DEPTH = PATTERN_REG_CHARS
) (
   input  logic [WIN_DEPTH-1:0][CHAR_W-1:0] win_chars,   // entry 0 newest, folded
   input  logic [PATTERN_BITS-1:0]          pattern,     // char 0 in low byte
   input  logic [LEN_W-1:0]                 active_len,  // 1 .. WIN_DEPTH
   output logic                             window_hit
);

   logic [WIN_DEPTH-1:0] pos_ok;

   // window entry k lines up with pattern char active_len-1-k
   for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_pos
      logic [LEN_W-1:0]  pat_idx;
      logic [CHAR_W-1:0] pat_char;
      logic              in_use;

      assign in_use   = LEN_W'(k) < active_len;
      assign pat_idx  = active_len - LEN_W'(1) - LEN_W'(k);
      assign pat_char = fold_case(pattern[pat_idx[4:0]*CHAR_W +: CHAR_W]);
      assign pos_ok[k] = !in_use || (win_chars[k] == pat_char);
   end

   assign window_hit = &pos_ok;

endmodule

FILE: rtl/core/case_insensitive_substring_matcher_unit.sv
// case_insensitive_substring_matcher_unit: top level of the text matcher.
// Depends on cism_pkg and cism_window_compare.
//
//  channel | direction | tuser                 | tdata (low bit up)
//  req     | in        | command[1:0]          | text_byte[7:0]
//  rsp     | out       | result_kind[0]        | line_number[31:0], total_matches[63:32]
//  csr     | in        | -                     | csr_index selects register, csr_wdata[63:0]
//
// One item per cycle while the result register is free or being drained; a result passes
// the input register, the single window compare stage and the result register.
// Synchronous active-high reset clears valids and counts; line, pattern length reset to 1.
// A stalled result holds the result register; the input register keeps taking
// items while the result register is free or being drained.
module case_insensitive_substring_matcher_unit
   import cism_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // text_byte[7:0]
   input  logic [CMD_W-1:0]      req_tuser,   // command[1:0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // line_number[31:0], total_matches[63:32]
   output logic                  rsp_tuser,   // result_kind[0]
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WIN_DEPTH = (PATTERN_MAX < PATTERN_REG_CHARS) ? PATTERN_MAX
                                                                : PATTERN_REG_CHARS;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(WIN_DEPTH);

   // configuration registers
   logic [LEN_W-1:0]        pat_len_ff;
   logic [PATTERN_BITS-1:0] pattern_ff;

   // input register
   logic              in_valid_ff;
   logic [CMD_W-1:0]  in_cmd_ff;
   logic [CHAR_W-1:0] in_byte_ff;

   // matcher state
   logic [WIN_DEPTH-1:0][CHAR_W-1:0] win_ff, win_in;
   logic [LEN_W-1:0]   chars_ff, chars_in;
   logic [COUNT_W-1:0] line_ff, line_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   // result register
   logic               out_valid_ff;
   logic               out_kind_ff, out_kind_in;
   logic [COUNT_W-1:0] out_line_ff, out_line_in;
   logic [COUNT_W-1:0] out_total_ff, out_total_in;
   logic               res_valid;

   logic              advance;
   logic [LEN_W-1:0]  active_len;
   logic              window_hit;
   logic [LEN_W-1:0]  chars_inc;
   logic [COUNT_W-1:0] total_inc;

   // handshake: the item moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= LEN_W'(1);
         pattern_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAT_LEN:  pat_len_ff <= csr_wdata[LEN_W-1:0];
            CSR_PAT_LOW:  pattern_ff[0*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            CSR_PAT_SEC:  pattern_ff[1*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            CSR_PAT_THD:  pattern_ff[2*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            CSR_PAT_HIGH: pattern_ff[3*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // length in use: zero means one, clamp to window depth
   always_comb begin
      active_len = pat_len_ff;
      if (pat_len_ff == '0) begin
         active_len = LEN_W'(1);
      end
      if (active_len > LEN_CAP) begin
         active_len = LEN_CAP;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // shifted window with the new folded character in front
   always_comb begin
      win_in[0] = fold_case(in_byte_ff);
      for (int k = 1; k < WIN_DEPTH; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   cism_window_compare #(
      .WIN_DEPTH (WIN_DEPTH)
   ) u_compare (
      .win_chars  (win_in),
      .pattern    (pattern_ff),
      .active_len (active_len),
      .window_hit (window_hit)
   );

   assign chars_inc = (chars_ff == CHARS_CAP) ? chars_ff : chars_ff + LEN_W'(1);
   assign total_inc = (total_ff == COUNT_MAX) ? total_ff : total_ff + COUNT_W'(1);

   // per-command state update and result
   always_comb begin
      chars_in     = chars_ff;
      line_in      = line_ff;
      total_in     = total_ff;
      res_valid    = 1'b0;
      out_kind_in  = KIND_MATCH;
      out_line_in  = line_ff;
      out_total_in = total_ff;
      case (in_cmd_ff)
         CMD_CHAR: begin
            chars_in = chars_inc;
            if (window_hit && (chars_inc >= active_len)) begin
               total_in     = total_inc;
               res_valid    = 1'b1;
               out_total_in = total_inc;
            end
         end
         CMD_EOL: begin
            chars_in = '0;
            line_in  = (line_ff == COUNT_MAX) ? line_ff : line_ff + COUNT_W'(1);
         end
         CMD_EOT: begin
            chars_in     = '0;
            line_in      = COUNT_W'(1);
            total_in     = '0;
            res_valid    = 1'b1;
            out_kind_in  = KIND_TOTAL;
            out_line_in  = '0;
         end
         default: ;
      endcase
   end

   // matcher counters
   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= '0;
         line_ff  <= COUNT_W'(1);
         total_ff <= '0;
      end else if (advance) begin
         chars_ff <= chars_in;
         line_ff  <= line_in;
         total_ff <= total_in;
      end
   end

   // window shifts on every character transfer
   always_ff @(posedge clock) begin
      if (advance && in_cmd_ff == CMD_CHAR) begin
         win_ff <= win_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_kind_ff  <= out_kind_in;
         out_line_ff  <= out_line_in;
         out_total_ff <= out_total_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {out_total_ff, out_line_ff};

endmodule

FILE: rtl/core/cism_checker.sv
// cism_checker: port-level checks on the matcher's result stream, bound to
// the top level. Depends on cism_pkg and case_insensitive_substring_matcher_unit.
module cism_checker
   import cism_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [7:0]            req_tdata,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [63:0]           rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // a stalled result transfer holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // total report carries line number zero
   a_total_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TOTAL |-> rsp_tdata[31:0] == '0)
      else $error("total report with nonzero line");

   // a match reports a real line and a nonzero running count
   a_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_MATCH |->
         rsp_tdata[31:0] != '0 && rsp_tdata[63:32] != '0)
      else $error("match result with zero line or count");

endmodule

bind case_insensitive_substring_matcher_unit cism_checker u_cism_checker (.*);

FILE: tb/tb_case_insensitive_substring_matcher_unit.sv
// tb_case_insensitive_substring_matcher_unit: self-checking testbench for the text matcher.
// Depends on cism_pkg and case_insensitive_substring_matcher_unit; a predictor class
// tracks the folded window and the line and match counters and checks every result transfer.
`timescale 1ns / 1ps

import cism_pkg::*;

typedef struct packed {
   logic               kind;
   logic [COUNT_W-1:0] line_no;
   logic [COUNT_W-1:0] total;
} match_report_type;

// predicts match and total reports from accepted text transfers
class line_match_predictor;
   logic [LEN_W-1:0]      len_reg;
   logic [CSR_DATA_W-1:0] pattern_reg [4];
   logic [CHAR_W-1:0]     window [PATTERN_MAX_DEFAULT];
   logic [LEN_W-1:0]      line_chars;
   logic [COUNT_W-1:0]    line_count;
   logic [COUNT_W-1:0]    hit_count;
   match_report_type      expected_reports [$];
   int unsigned           failures;

   function new();
      len_reg = LEN_W'(1);
      foreach (pattern_reg[i]) pattern_reg[i] = '0;
      clear_text();
      failures = 0;
   endfunction

   function void clear_text();
      foreach (window[i]) window[i] = '0;
      line_chars = '0;
      line_count = COUNT_W'(1);
      hit_count  = '0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PAT_LEN:  len_reg = value[LEN_W-1:0];
         CSR_PAT_LOW:  pattern_reg[0] = value;
         CSR_PAT_SEC:  pattern_reg[1] = value;
         CSR_PAT_THD:  pattern_reg[2] = value;
         CSR_PAT_HIGH: pattern_reg[3] = value;
         default: ;
      endcase
   endfunction

   // zero acts as one, long lengths clamp to the window depth
   function int unsigned active_length();
      int unsigned n;
      n = len_reg;
      if (n == 0) n = 1;
      if (n > PATTERN_MAX_DEFAULT) n = PATTERN_MAX_DEFAULT;
      if (n > PATTERN_REG_CHARS) n = PATTERN_REG_CHARS;
      return n;
   endfunction

   // only ascii A..Z (8'h41..8'h5A) fold
   function logic [CHAR_W-1:0] lower_ascii(logic [CHAR_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
      return c;
   endfunction

   function void take_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
      int unsigned      n;
      int               i;
      bit               hit;
      match_report_type r;
      n = active_length();
      case (cmd)
         CMD_CHAR: begin
            for (i = PATTERN_MAX_DEFAULT - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = lower_ascii(ch);
            if (line_chars != CHARS_CAP) line_chars++;
            hit = (line_chars >= n);
            // pattern char i lines up with the char n-1-i transfers back
            for (i = 0; i < n; i++) begin
               if (window[n-1-i] != lower_ascii(pattern_reg[i/8][(i%8)*8 +: 8])) hit = 1'b0;
            end
            if (hit) begin
               if (hit_count != COUNT_MAX) hit_count++;
               r.kind    = KIND_MATCH;
               r.line_no = line_count;
               r.total   = hit_count;
               expected_reports.push_back(r);
            end
         end
         CMD_EOL: begin
            if (line_count != COUNT_MAX) line_count++;
            line_chars = '0;
         end
         CMD_EOT: begin
            r.kind    = KIND_TOTAL;
            r.line_no = '0;
            r.total   = hit_count;
            expected_reports.push_back(r);
            clear_text();
         end
         default: ;
      endcase
   endfunction

   function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
   endfunction

   function void check_report(logic kind, logic [COUNT_W-1:0] line_no,
                              logic [COUNT_W-1:0] total);
      match_report_type want;
      if (expected_reports.size() == 0) begin
         note_failure($sformatf("unexpected result: kind %0d line %0d total %0d",
                                kind, line_no, total));
         return;
      end
      want = expected_reports.pop_front();
      if (kind !== want.kind || line_no !== want.line_no || total !== want.total) begin
         note_failure($sformatf({"result mismatch: expected kind %0d line %0d total %0d, ",
                                 "got kind %0d line %0d total %0d"},
                                want.kind, want.line_no, want.total, kind, line_no, total));
      end
   endfunction

   function int unsigned pending();
      return expected_reports.size();
   endfunction

   function int unsigned final_failures();
      if (expected_reports.size() != 0) begin
         note_failure($sformatf("%0d expected results never arrived",
                                expected_reports.size()));
      end
      return failures;
   endfunction
endclass

module tb_case_insensitive_substring_matcher_unit;

   localparam int CLOCK_PERIOD  = 4;
   localparam int GAP_MAX       = 18;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_PHASE    = 2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // pacing modes for either side
   localparam int PACE_NONE   = 0;
   localparam int PACE_FULL   = 1;
   localparam int PACE_SPARSE = 2;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // text_byte[7:0]
   logic [CMD_W-1:0]      req_tuser  = '0;   // command[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [63:0]           rsp_tdata;         // line_number[31:0], total_matches[63:32]
   logic                  rsp_tuser;         // result_kind[0]
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   line_match_predictor matcher;
   int                  req_pace = PACE_SPARSE;
   int                  rsp_pace = PACE_SPARSE;
   bit                  hold_request = 1'b0;
   int unsigned         items_sent = 0;
   logic [CHAR_W-1:0]   pat_chars [PATTERN_REG_CHARS];

   case_insensitive_substring_matcher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap(int pace);
      if (pace == PACE_FULL) return $urandom_range(0, GAP_MAX);
      if (pace == PACE_SPARSE && $urandom_range(0, 7) == 0) return $urandom_range(1, GAP_MAX);
      return 0;
   endfunction

   // letters randomly change case, everything else passes as is
   function automatic logic [7:0] swap_case(logic [7:0] c);
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
         return c ^ 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] pattern_byte(int unsigned style);
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0:       c = 8'h61;
         1:       c = 8'h41;
         2:       c = 8'h62;
         default: c = 8'h42;
      endcase
      if (style == 7) c = 8'($urandom_range(0, 255));
      else if (style == 8) c = 8'hFF;
      else if (style == 9) c = 8'h00;
      else if (style >= 5 && $urandom_range(0, 2) == 0) begin
         // bytes next to the letter ranges, zero and non-ascii look-alikes
         case ($urandom_range(0, 5))
            0:       c = 8'h40;
            1:       c = 8'h5B;
            2:       c = 8'h60;
            3:       c = 8'h7B;
            4:       c = 8'h00;
            default: c = 8'hC1;
         endcase
      end
      return c;
   endfunction

   // offer one item after a drawn gap and hold it until the transfer
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] ch);
      int gap;
      gap = pick_gap(req_pace);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = ch;
      do @(posedge clock); while (!req_tready);
      matcher.take_request(cmd, ch);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // sender pauses until every expected result is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (matcher.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      matcher.set_register(idx, value);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] len_word,
                            input logic [PATTERN_BITS-1:0] pat_bits);
      csr_write(CSR_PAT_LEN, len_word);
      csr_write(CSR_PAT_LOW, pat_bits[63:0]);
      csr_write(CSR_PAT_SEC, pat_bits[127:64]);
      csr_write(CSR_PAT_THD, pat_bits[191:128]);
      csr_write(CSR_PAT_HIGH, pat_bits[255:192]);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one stretch of text under one pattern setting
   task automatic run_phase(input bit long_hold);
      int unsigned           len_raw, pick, style, stop_at, line_goal, line_done, n, bad, i;
      logic [PATTERN_BITS-1:0] pat_bits;
      logic [CSR_DATA_W-1:0] len_word;
      logic [7:0]            c;
      settle();
      // length, with the zero and over-long encodings now and then
      case ($urandom_range(0, 9))
         0:       len_raw = 1;
         1:       len_raw = 32;
         2:       len_raw = 0;
         3:       len_raw = $urandom_range(33, 63);
         4, 5:    len_raw = $urandom_range(9, 31);
         default: len_raw = $urandom_range(2, 8);
      endcase
      style = $urandom_range(0, 9);
      if (long_hold) begin
         len_raw = 1;
         style   = 0;
      end
      for (i = 0; i < PATTERN_REG_CHARS; i++) begin
         pat_chars[i]          = pattern_byte(style);
         pat_bits[i*8 +: 8]    = pat_chars[i];
      end
      len_word = CSR_DATA_W'(len_raw);
      // upper bits of the length write are ignored
      if ($urandom_range(0, 3) == 0)
         len_word[CSR_DATA_W-1:LEN_W] = (CSR_DATA_W-LEN_W)'({$urandom, $urandom});
      configure(len_word, pat_bits);
      n = matcher.active_length();
      req_pace = $urandom_range(PACE_NONE, PACE_SPARSE);
      rsp_pace = $urandom_range(PACE_NONE, PACE_SPARSE);
      if (long_hold) begin
         req_pace     = PACE_NONE;
         hold_request = 1'b1;
      end
      stop_at = items_sent + $urandom_range(60, 200);
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) line_goal = $urandom_range(60, 90);
         else if (pick < 6) line_goal = $urandom_range(25, 50);
         else line_goal = $urandom_range(0, 24);
         line_done = 0;
         while (line_done < line_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               // whole pattern in mixed case, sometimes with one char broken
               bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
               for (i = 0; i < n; i++) begin
                  c = swap_case(pat_chars[i]);
                  if (i == bad) c = c ^ (8'h01 << $urandom_range(0, 7));
                  send_item(CMD_CHAR, c);
               end
               line_done += n;
            end else if (pick < 28) begin
               send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
            end else if (pick < 40) begin
               send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
               line_done++;
            end else begin
               send_item(CMD_CHAR, swap_case(pat_chars[$urandom_range(0, n - 1)]));
               line_done++;
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 86) send_item(CMD_EOL, 8'($urandom_range(0, 255)));
         else if (pick < 94) send_item(CMD_EOT, 8'($urandom_range(0, 255)));
      end
      // leave a partial line so the next pattern compares against old chars
      if ($urandom_range(0, 2) == 0) begin
         for (i = 0; i <= n / 2; i++) send_item(CMD_CHAR, swap_case(pat_chars[i]));
      end
   endtask

   // no-progress watchdog
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // result side: random stalls, one long hold on request
   initial begin : receiver
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap(rsp_pace);
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         matcher.check_report(rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
      end
   end

   initial begin : stimulus
      int phase;
      matcher = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setting: length 1, zero pattern byte, so byte zero matches
      send_item(CMD_CHAR, 8'h00);
      send_item(CMD_CHAR, 8'h61);
      send_item(CMD_CHAR, 8'hFF);
      send_item(CMD_EOL, 8'hA5);
      send_item(CMD_UNUSED, 8'h00);
      send_item(CMD_CHAR, 8'h00);
      send_item(CMD_EOT, 8'h5A);
      settle();

      // "aBa": overlapping matches, nothing counted across a line end
      configure(64'd3, {192'd0, 64'h0000_0000_0061_4261});
      send_item(CMD_CHAR, 8'h41);
      send_item(CMD_CHAR, 8'h62);
      send_item(CMD_CHAR, 8'h41);
      send_item(CMD_CHAR, 8'h42);
      send_item(CMD_CHAR, 8'h61);
      send_item(CMD_CHAR, 8'h62);
      send_item(CMD_EOL, 8'h00);
      send_item(CMD_CHAR, 8'h61);
      send_item(CMD_EOT, 8'hFF);
      settle();

      // length zero acts as one; only A..Z fold, neighbors and high bytes do not
      configure(64'd0, {{192{1'b1}}, 64'h5A});
      send_item(CMD_CHAR, 8'h7A);
      send_item(CMD_CHAR, 8'h5A);
      send_item(CMD_CHAR, 8'h5B);
      send_item(CMD_CHAR, 8'h40);
      send_item(CMD_CHAR, 8'hDA);
      send_item(CMD_EOT, 8'h00);

      // random stretches under changing patterns
      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         run_phase(phase == HOLD_PHASE);
         phase++;
      end
      settle();

      if (matcher.final_failures() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
